FILE: hw/rtl/mstk_pkg.sv
// Package for the minimum spanning tree engine: request and result payloads,
// controller-to-datapath command and status groups, opcodes and defaults.
// No dependencies; every other file of the block but mstk_ram uses it.
`default_nettype none

package mstk_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  // Vertex count register value after reset
  localparam logic [4:0] VERTEX_COUNT_RESET = 5'd16;

  // Request opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  // One input request
  typedef struct packed {
    logic        opcode;
    logic [3:0]  node_a;
    logic [3:0]  node_b;
    logic [15:0] weight;
  } in_req_t;

  // One result item
  typedef struct packed {
    logic [3:0]  tree_node_low;
    logic [3:0]  tree_node_high;
    logic [15:0] tree_weight;
    logic        edge_valid;
    logic        spanning;
    logic        last;
  } out_res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;
    logic add;
    logic start;
    logic linit_step;
    logic scan_start;
    logic scan_step;
    logic remove;
    logic rd_b;
    logic sweep_start;
    logic sweep_step;
    logic emit_edge;
    logic emit_mark;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_done;
    logic v_last;
    logic scan_last;
    logic found;
    logic same;
    logic joined_full;
    logic eff_le1;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/minimum_spanning_tree_kruskal_top.sv
// Top level of the minimum spanning tree engine: joins controller and datapath.
// Depends on mstk_pkg, mstk_ctrl, mstk_dp and mstk_ram.
//
//   channel  direction  payload               handshake
//   cfg      in         cfg_data (5 bits)     cfg_valid / cfg_ready
//   in       in         mstk_pkg::in_req_t    in_valid / in_ready
//   out      out        mstk_pkg::out_res_t   out_valid / out_ready
//
// After reset the edge store is cleared, one entry a cycle, all MAX_VERTICES
// squared entries (256 by default); no request is taken meanwhile, cfg writes are.
// A valid add request is written straight into the edge store. A build request runs
// on its own: label setup, then per scan pass a read of every vertex pair, and
// when the lightest edge merges two components a label sweep, then hand-off;
// the single read port of the edge store sets the scan length.
// A result waits in the output register while loads go on; a stalled output
// stalls the build only when the next result is ready.
`default_nettype none

module minimum_spanning_tree_kruskal_top #(
  parameter int MAX_VERTICES = mstk_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mstk_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire mstk_pkg::in_req_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      mstk_pkg::out_res_t out_data
);

  mstk_pkg::dp_cmd_t  cmd;
  mstk_pkg::dp_stat_t stat;

  // The user must write the register only while idle; the block does not enforce it, so take writes at once
  assign cfg_ready = 1'b1;

  mstk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .stat      (stat),
    .cmd       (cmd)
  );

  mstk_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mstk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mstk_ctrl.sv
// Controller state machine of the spanning tree engine: sequences the
// clearing pass, loads, label setup, scans, merges and result hand-off.
// Depends on mstk_pkg (command and status types, opcodes).
`default_nettype none

module mstk_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_opcode,
  input  wire mstk_pkg::dp_stat_t stat,
  output      mstk_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LINIT  = 4'd2;
  localparam logic [3:0] S_SCAN0  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SWAIT  = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_RDA    = 4'd7;
  localparam logic [3:0] S_RDB    = 4'd8;
  localparam logic [3:0] S_SWEEP  = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;
  localparam logic [3:0] S_MARK   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       in_acc;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == mstk_pkg::OP_BUILD) begin
            cmd.start  = 1'b1;
            state_next = stat.eff_le1 ? S_MARK : S_LINIT;
          end else begin
            cmd.add = 1'b1;
          end
        end
      end
      S_LINIT: begin
        cmd.linit_step = 1'b1;
        if (stat.v_last) begin
          state_next = S_SCAN0;
        end
      end
      S_SCAN0: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SWAIT;
        end
      end
      S_SWAIT: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.found) begin
          cmd.remove = 1'b1;
          state_next = S_RDA;
        end else begin
          state_next = S_MARK;
        end
      end
      S_RDA: begin
        cmd.rd_b   = 1'b1;
        state_next = S_RDB;
      end
      S_RDB: begin
        if (stat.same) begin
          state_next = S_SCAN0;
        end else begin
          cmd.sweep_start = 1'b1;
          state_next      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.v_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_edge = 1'b1;
          state_next    = stat.joined_full ? S_IDLE : S_SCAN0;
        end
      end
      S_MARK: begin
        if (stat.out_free) begin
          cmd.emit_mark = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mstk_dp.sv
// Datapath of the spanning tree engine: vertex count register, edge store,
// component labels, scan for the lightest edge, label merge, result register.
// Depends on mstk_pkg and mstk_ram.
`default_nettype none

module mstk_dp #(
  parameter int MAX_VERTICES = mstk_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = mstk_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [4:0]         cfg_data,
  input  wire mstk_pkg::in_req_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      mstk_pkg::out_res_t out_data,
  input  wire mstk_pkg::dp_cmd_t  cmd,
  output      mstk_pkg::dp_stat_t stat
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (CW > 4) ? CW : 4;
  localparam int ED = MAX_VERTICES * MAX_VERTICES;
  localparam int AW = $clog2(ED);
  localparam int EW = WEIGHT_BITS + 1;

  // Vertex count register and its saturated value
  logic [4:0]    vcount;
  logic [CW-1:0] eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= mstk_pkg::VERTEX_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vcount <= cfg_data;
    end
  end

  always_comb begin
    if (vcount == '0) begin
      eff = CW'(1);
    end else if (int'(vcount) > MAX_VERTICES) begin
      eff = CW'(MAX_VERTICES);
    end else begin
      eff = CW'(vcount);
    end
  end

  // Count latched for one build run
  logic [CW-1:0] n_lat;
  logic [VW-1:0] nm1;
  logic [VW-1:0] nm2;
  logic [CW-1:0] joined;

  assign nm1 = VW'(n_lat - CW'(1));
  assign nm2 = VW'(n_lat - CW'(2));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_lat  <= eff;
      joined <= CW'(1);
    end else if (cmd.emit_edge) begin
      joined <= joined + CW'(1);
    end
  end

  // Edge store ports
  logic          e_we;
  logic [AW-1:0] e_waddr;
  logic [EW-1:0] e_wdata;
  logic [AW-1:0] e_raddr;
  logic [EW-1:0] e_rdata;

  mstk_ram #(
    .WIDTH (EW),
    .DEPTH (ED)
  ) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  // Label store ports
  logic          l_we;
  logic [VW-1:0] l_waddr;
  logic [VW-1:0] l_wdata;
  logic [VW-1:0] l_raddr;
  logic [VW-1:0] l_rdata;

  mstk_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_label_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // Clearing pass counter
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Add request: order the pair and check it
  logic [3:0]    lo;
  logic [3:0]    hi;
  logic          add_ok;
  logic [AW-1:0] add_addr;

  assign lo       = (in_data.node_a < in_data.node_b) ? in_data.node_a : in_data.node_b;
  assign hi       = (in_data.node_a < in_data.node_b) ? in_data.node_b : in_data.node_a;
  assign add_ok   = (in_data.node_a != in_data.node_b) &&
                    (XW'(in_data.node_a) < XW'(eff)) && (XW'(in_data.node_b) < XW'(eff));
  assign add_addr = AW'(lo) * AW'(MAX_VERTICES) + AW'(hi);

  // Scan counters, delayed read tags and best edge so far
  logic [VW-1:0]          si;
  logic [VW-1:0]          sj;
  logic                   rd_d;
  logic [VW-1:0]          ri_d;
  logic [VW-1:0]          rj_d;
  logic                   found;
  logic [VW-1:0]          br;
  logic [VW-1:0]          bc;
  logic [WEIGHT_BITS-1:0] bw;
  logic [AW-1:0]          best_addr;

  assign best_addr = AW'(br) * AW'(MAX_VERTICES) + AW'(bc);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_d  <= 1'b0;
      found <= 1'b0;
    end else begin
      rd_d <= cmd.scan_step;
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (rd_d && e_rdata[WEIGHT_BITS] &&
                   (!found || e_rdata[WEIGHT_BITS-1:0] < bw)) begin
        found <= 1'b1;
      end
    end
  end

  // Advance the pair counters row by row and keep the lightest edge
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      si <= '0;
      sj <= VW'(1);
    end else if (cmd.scan_step) begin
      ri_d <= si;
      rj_d <= sj;
      if (sj == nm1) begin
        si <= si + VW'(1);
        sj <= si + VW'(2);
      end else begin
        sj <= sj + VW'(1);
      end
    end
    if (rd_d && e_rdata[WEIGHT_BITS] && (!found || e_rdata[WEIGHT_BITS-1:0] < bw)) begin
      br <= ri_d;
      bc <= rj_d;
      bw <= e_rdata[WEIGHT_BITS-1:0];
    end
  end

  // Edge store write and read selection
  always_comb begin
    e_we    = 1'b0;
    e_waddr = clr_addr;
    e_wdata = '0;
    if (cmd.clr_step) begin
      e_we = 1'b1;
    end else if (cmd.add && add_ok) begin
      e_we    = 1'b1;
      e_waddr = add_addr;
      e_wdata = {1'b1, WEIGHT_BITS'(in_data.weight)};
    end else if (cmd.remove) begin
      e_we    = 1'b1;
      e_waddr = best_addr;
    end
  end

  assign e_raddr = AW'(si) * AW'(MAX_VERTICES) + AW'(sj);

  // Label setup and merge sweep
  logic [VW-1:0] v;
  logic [VW-1:0] la;
  logic [VW-1:0] from_lbl;
  logic [VW-1:0] to_lbl;
  logic          sw_d;
  logic [VW-1:0] sw_v_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_d <= 1'b0;
    end else begin
      sw_d <= cmd.sweep_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.sweep_start) begin
      v <= '0;
    end else if (cmd.linit_step || cmd.sweep_step) begin
      v <= v + VW'(1);
    end
    if (cmd.rd_b) begin
      la <= l_rdata;
    end
    if (cmd.sweep_start) begin
      from_lbl <= l_rdata;
      to_lbl   <= la;
    end
    if (cmd.sweep_step) begin
      sw_v_d <= v;
    end
  end

  always_comb begin
    l_we    = 1'b0;
    l_waddr = v;
    l_wdata = v;
    if (cmd.linit_step) begin
      l_we = 1'b1;
    end else if (sw_d && (l_rdata == from_lbl)) begin
      l_we    = 1'b1;
      l_waddr = sw_v_d;
      l_wdata = to_lbl;
    end
  end

  always_comb begin
    l_raddr = v;
    if (cmd.remove) begin
      l_raddr = br;
    end else if (cmd.rd_b) begin
      l_raddr = bc;
    end
  end

  // Result register
  logic out_free;
  logic full;

  assign out_free = !out_valid || out_ready;
  assign full     = ((joined + CW'(1)) == n_lat);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_edge || cmd.emit_mark) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_edge) begin
      out_data.tree_node_low  <= 4'(br);
      out_data.tree_node_high <= 4'(bc);
      out_data.tree_weight    <= 16'(bw);
      out_data.edge_valid     <= 1'b1;
      out_data.spanning       <= full;
      out_data.last           <= full;
    end else if (cmd.emit_mark) begin
      out_data.tree_node_low  <= '0;
      out_data.tree_node_high <= '0;
      out_data.tree_weight    <= '0;
      out_data.edge_valid     <= 1'b0;
      out_data.spanning       <= (n_lat == CW'(1));
      out_data.last           <= 1'b1;
    end
  end

  // Status back to the controller
  assign stat.clr_done    = (clr_addr == AW'(ED - 1));
  assign stat.v_last      = (v == nm1);
  assign stat.scan_last   = (si == nm2) && (sj == nm1);
  assign stat.found       = found;
  assign stat.same        = (l_rdata == la);
  assign stat.joined_full = full;
  assign stat.eff_le1     = (eff == CW'(1));
  assign stat.out_free    = out_free;

endmodule

`default_nettype wire

FILE: hw/rtl/mstk_checker.sv
// Port-level checks of the spanning tree engine, bound to its top level.
// Depends on mstk_pkg and minimum_spanning_tree_kruskal_top.
`default_nettype none

module mstk_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire mstk_pkg::out_res_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Take no request at the start of the clearing pass that follows reset
  a_no_req_after_rst: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken before the edge store is clear");

  // Only the final result of a run may be a marker, and a marker carries zero vertices and weight
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.edge_valid |->
      out_data.last && out_data.tree_node_low == '0 &&
      out_data.tree_node_high == '0 && out_data.tree_weight == '0)
    else $error("marker result malformed");

  // Drop nothing into spanning unless the run ends there
  a_span_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.spanning |-> out_data.last)
    else $error("spanning flag on a non-final result");

  // A tree edge names two distinct vertices in order
  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.edge_valid |->
      out_data.tree_node_low < out_data.tree_node_high)
    else $error("tree edge vertices out of order");

endmodule

bind minimum_spanning_tree_kruskal_top mstk_checker u_mstk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
